// ----- rtl/clb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_pkg: shared types and constants of the cell list binning block
// Field widths, register indexes, result codes and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package clb_pkg;

	localparam int AXES       = 3;
	localparam int COORD_W    = 16;
	localparam int IN_DATA_W  = 48;
	localparam int MESH_W     = 5;
	localparam int BOX_W      = 16;
	localparam int INV_W      = 24;
	localparam int FRAC_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam int OUT_IDX_W    = 12;
	localparam int OUT_CELL_W   = 4;
	localparam int OUT_FIELDS_W = 2 * OUT_IDX_W + AXES * OUT_CELL_W;
	localparam int OUT_DATA_W   = 40;
	localparam int OUT_USER_W   = 3;

	localparam logic [MESH_W-1:0] MESH_RST = 5'd16;
	localparam logic [BOX_W-1:0]  BOX_RST  = 16'd0;
	localparam logic [INV_W-1:0]  INV_RST  = 24'd256;

	localparam logic [CFG_IDX_W-1:0] REG_MESH_CELLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SPAN   = 2'd2;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_CLEARED  = 2'd2
	} status_t;

	typedef struct packed {
		logic    load_item;
		logic    head_read;
		logic    commit;
		logic    out_load;
		status_t out_kind;
		logic    sweep_write;
		logic    count_clear;
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic full;
		logic sweep_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/clb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module clb_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/clb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_ctrl: sequencer of the cell list binning block
// Steps one item at a time through binning, head update or head sweep.
// ----------------------------------------------------------------------------
module clb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output clb_pkg::cmd_t cmd,
	input  clb_pkg::sts_t sts
);
	import clb_pkg::*;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DIFF,
		S_MUL1,
		S_MUL2,
		S_CLAMP,
		S_ADDR,
		S_READ,
		S_WRITE,
		S_SWEEP,
		S_RESP
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_item = in_valid;
			end
			S_READ: begin
				cmd.head_read = 1'b1;
			end
			S_WRITE: begin
				cmd.commit   = sts.out_free;
				cmd.out_load = sts.out_free;
				cmd.out_kind = ST_INSERTED;
			end
			S_INIT, S_SWEEP: begin
				cmd.sweep_write = 1'b1;
				cmd.count_clear = sts.sweep_last;
			end
			S_RESP: begin
				cmd.out_load = sts.out_free;
				cmd.out_kind = sts.is_clear ? ST_CLEARED : ST_DROPPED;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (sts.sweep_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_DIFF;
				end
				S_DIFF: begin
					priority if (sts.is_clear) state_q <= S_SWEEP;
					else if (sts.full) state_q <= S_RESP;
					else state_q <= S_MUL1;
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_ADDR;
				S_ADDR:  state_q <= S_READ;
				S_READ:  state_q <= S_WRITE;
				S_WRITE: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				S_SWEEP: begin
					if (sts.sweep_last) state_q <= S_RESP;
				end
				S_RESP: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/clb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_datapath: binning arithmetic, tables and result register
// Three axis lanes map coordinates to cells, the head table is updated
// read-modify-write and the old head is written as the particle's link.
// ----------------------------------------------------------------------------
module clb_datapath #(
	parameter int MESH_MAX      = 16,
	parameter int MAX_PARTICLES = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [clb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [clb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_action,
	input  logic [clb_pkg::IN_DATA_W-1:0]     in_data,
	input  clb_pkg::cmd_t                     cmd,
	output clb_pkg::sts_t                     sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [clb_pkg::OUT_DATA_W-1:0]    out_data,
	output logic [clb_pkg::OUT_USER_W-1:0]    out_user
);
	import clb_pkg::*;

	localparam int CELL_COUNT = MESH_MAX * MESH_MAX * MESH_MAX;
	localparam int AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int CW    = (MESH_MAX > 1) ? $clog2(MESH_MAX) : 1;
	localparam int MW    = $clog2(MESH_MAX + 1);
	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int ENT_W = IDX_W + 1;
	localparam int P1_W  = COORD_W + INV_W;
	localparam int P2_W  = P1_W + MW;
	localparam int CR_W  = P2_W - FRAC_W;
	localparam int PAD_W = OUT_DATA_W - OUT_FIELDS_W;

	// configuration
	logic [MESH_W-1:0] mesh_cells_q;
	logic [BOX_W-1:0]  box_min_q;
	logic [INV_W-1:0]  inv_span_q;
	logic [MW-1:0]     mesh;
	logic [MW-1:0]     mesh_m1;

	// item and lane stages
	logic               action_q;
	logic [COORD_W-1:0] coord_q  [AXES];
	logic [COORD_W-1:0] diff_s1  [AXES];
	logic [P1_W-1:0]    prod1_s2 [AXES];
	logic [P2_W-1:0]    prod2_s3 [AXES];
	logic [CW-1:0]      cell_s4  [AXES];
	logic [CW-1:0]      cell_clamped [AXES];
	logic [CR_W-1:0]    cell_raw [AXES];
	logic [AXES-1:0]    below_s1;
	logic [AXES-1:0]    below_s2;
	logic [AXES-1:0]    below_s3;
	logic [AW-1:0]      addr_s5;

	// tables and counters
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    sweep_q;
	logic             sweep_last;
	logic             head_we;
	logic [AW-1:0]    head_waddr;
	logic [ENT_W-1:0] head_wdata;
	logic [ENT_W-1:0] head_rd;
	logic             old_valid;
	logic [IDX_W-1:0] old_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_cells_q <= MESH_RST;
			box_min_q    <= BOX_RST;
			inv_span_q   <= INV_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MESH_CELLS: mesh_cells_q <= cfg_data[MESH_W-1:0];
				REG_BOX_MIN:    box_min_q    <= cfg_data[BOX_W-1:0];
				REG_INV_SPAN:   inv_span_q   <= cfg_data[INV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// cells in use, zero taken as one and saturated at the built mesh size
	always_comb begin
		priority if (mesh_cells_q == '0) mesh = MW'(1);
		else if (32'(mesh_cells_q) > MESH_MAX) mesh = MW'(MESH_MAX);
		else mesh = MW'(mesh_cells_q);
		mesh_m1 = mesh - MW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= in_action;
			for (int a = 0; a < AXES; a++) begin
				coord_q[a] <= in_data[a*COORD_W +: COORD_W];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			cell_raw[a] = prod2_s3[a][P2_W-1:FRAC_W];
			priority if (below_s3[a]) cell_clamped[a] = '0;
			else if (cell_raw[a] > CR_W'(mesh_m1)) cell_clamped[a] = CW'(mesh_m1);
			else cell_clamped[a] = CW'(cell_raw[a]);
		end
	end

	// lanes run freely, the sequencer knows when each stage holds the item
	always_ff @(posedge clk) begin
		for (int a = 0; a < AXES; a++) begin
			below_s1[a] <= coord_q[a] < box_min_q;
			diff_s1[a]  <= coord_q[a] - box_min_q;
			prod1_s2[a] <= P1_W'(diff_s1[a]) * P1_W'(inv_span_q);
			prod2_s3[a] <= P2_W'(prod1_s2[a]) * P2_W'(mesh);
			cell_s4[a]  <= cell_clamped[a];
		end
		below_s2 <= below_s1;
		below_s3 <= below_s2;
		addr_s5  <= AW'((32'(cell_s4[0]) * MESH_MAX + 32'(cell_s4[1])) * MESH_MAX
			+ 32'(cell_s4[2]));
	end

	assign sweep_last = (sweep_q == AW'(CELL_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.sweep_write) begin
				sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
			end
			if (cmd.count_clear) begin
				count_q <= '0;
			end else if (cmd.commit) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	assign head_we    = cmd.sweep_write | cmd.commit;
	assign head_waddr = cmd.sweep_write ? sweep_q : addr_s5;
	assign head_wdata = cmd.sweep_write ? '0 : {1'b1, count_q[IDX_W-1:0]};
	assign old_valid  = head_rd[IDX_W];
	assign old_idx    = head_rd[IDX_W-1:0];

	clb_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CELL_COUNT)
	) u_head_ram (
		.clk  (clk),
		.we   (head_we),
		.waddr(head_waddr),
		.wdata(head_wdata),
		.re   (cmd.head_read),
		.raddr(addr_s5),
		.rdata(head_rd)
	);

	clb_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_PARTICLES)
	) u_link_ram (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(old_valid ? head_rd : '0),
		.re   (1'b0),
		.raddr('0),
		.rdata()
	);

	assign sts.is_clear   = ~action_q;
	assign sts.full       = (count_q == CNT_W'(MAX_PARTICLES));
	assign sts.sweep_last = sweep_last;
	assign sts.out_free   = ~out_valid | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_kind == ST_INSERTED) begin
				out_data <= {{PAD_W{1'b0}},
					old_valid ? OUT_IDX_W'(old_idx) : {OUT_IDX_W{1'b0}},
					OUT_CELL_W'(cell_s4[2]), OUT_CELL_W'(cell_s4[1]),
					OUT_CELL_W'(cell_s4[0]), OUT_IDX_W'(count_q)};
				out_user <= {old_valid, cmd.out_kind};
			end else begin
				out_data <= '0;
				out_user <= {1'b0, cmd.out_kind};
			end
		end
	end

endmodule

// ----- rtl/cell_list_binning.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_list_binning: 3D cell linked list builder for neighbor search
// Bins particles into a cubic cell mesh and chains them through cell heads.
// ----------------------------------------------------------------------------
// One item at a time. An insert passes from its transfer through four lane
// stages (offset, span multiply, mesh multiply, clamp), a cell address stage
// and a read then a write of the one port pair of the head table before the
// input is ready again; the write waits while the output register holds a
// result not yet taken. A dropped insert skips the lanes. A clear sweeps the
// head table one cell a cycle. After reset the same sweep runs before the
// first item is taken; configuration writes are taken at any time. A finished
// result waits in the output register while the next item is accepted.
module cell_list_binning #(
	parameter int MESH_MAX      = 16,
	parameter int MAX_PARTICLES = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [clb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// coord_x [15:0], coord_y [31:16], coord_z [47:32]
	input  logic [clb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// action [0]
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// particle_index [11:0], cell_x [15:12], cell_y [19:16], cell_z [23:20],
	// link_index [35:24], zero [39:36]
	output logic [clb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// status [1:0], link_valid [2]
	output logic [clb_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import clb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	clb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	clb_datapath #(
		.MESH_MAX     (MESH_MAX),
		.MAX_PARTICLES(MAX_PARTICLES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_action(s_axis_tuser),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser)
	);

endmodule
